>>> hw/rtl/slpd_pkg.sv
// ----------------------------------------------------------------------------
// slpd_pkg - shared types and constants of the packet deframer
// Field widths, function and result codes, register indexes and the
// buffer limit used to cap the accepted payload length.
// ----------------------------------------------------------------------------
package slpd_pkg;

    // Buffer size; the largest length the buffer takes is six bytes less
    localparam int BUFFER_BYTES = 4096;
    localparam int CAP_LIMIT    = BUFFER_BYTES - 6;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hBE;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hEF;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 12'd4090;

    // Request function codes
    localparam logic FUNC_DATA       = 1'b0;
    localparam logic FUNC_DISCONNECT = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_ABORT    = 2'd3
    } t_kind;

    // Configuration as seen by the framing logic
    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  limit;
    } t_cfg;

endpackage

>>> hw/rtl/slpd_in_if.sv
// ----------------------------------------------------------------------------
// slpd_in_if - received byte channel
// Valid/ready channel carrying one received byte or a disconnect event.
// ----------------------------------------------------------------------------
interface slpd_in_if
    import slpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, func, rx_byte, input ready);
    modport sink   (input valid, func, rx_byte, output ready);
endinterface

>>> hw/rtl/slpd_out_if.sv
// ----------------------------------------------------------------------------
// slpd_out_if - deframed result channel
// Valid/ready channel carrying payload bytes and packet status markers.
// ----------------------------------------------------------------------------
interface slpd_out_if
    import slpd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    logic [1:0]        kind;

    modport source (output valid, payload_byte, last, kind, input ready);
    modport sink   (input valid, payload_byte, last, kind, output ready);
endinterface

>>> hw/rtl/sync_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_packet_deframer - sync word / length prefixed deframer
// Hunts for a two-byte sync word, gathers a four-byte little-endian length
// and passes the payload through, with markers for empty, oversize and
// aborted packets.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    func, rx_byte
//   o_out    out  valid/ready    payload_byte, last, kind
//   cfg      in   i_cfg_we       i_cfg_index, i_cfg_data
//
// One request per clock is sustained while results are taken; a request passes
// through the input register and then the result register, with the frame
// state updated by a few byte compares in between.
// A stalled result holds in the result register; the input register fills
// behind it, then ready drops until the result is taken.
// Synchronous active-low reset returns to sync hunting with the register
// reset values; there is no clearing pass.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer
    import slpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    slpd_in_if.sink               i_in,
    slpd_out_if.source            o_out
);

    typedef enum logic [2:0] {
        ST_HUNT1   = 3'd0,
        ST_HUNT2   = 3'd1,
        ST_LEN0    = 3'd2,
        ST_LEN1    = 3'd3,
        ST_LEN2    = 3'd4,
        ST_LEN3    = 3'd5,
        ST_PAYLOAD = 3'd6
    } t_state;

    t_cfg w_cfg;

    slpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Input register
    logic              r_stg_vld;
    logic              r_stg_func;
    logic [BYTE_W-1:0] r_stg_byte;

    // Frame state: low length bits, flag for any higher bit, bytes left
    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len_lo, n_len_lo;
    logic              r_len_hi, n_len_hi;
    logic [LEN_W-1:0]  r_left, n_left;

    // Result register
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    t_kind             r_out_kind;

    logic              w_adv;
    logic              w_res_vld;
    logic [BYTE_W-1:0] w_res_byte;
    logic              w_res_last;
    t_kind             w_res_kind;
    logic              w_hi_all;
    logic [LEN_W-1:0]  w_left_dec;

    // Advance the input register when the result register can take a result
    assign w_adv       = r_stg_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_stg_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_stg_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_stg_func <= i_in.func;
            r_stg_byte <= i_in.rx_byte;
        end
    end

    assign w_hi_all   = r_len_hi || (r_stg_byte != '0);
    assign w_left_dec = r_left - LEN_W'(1);

    // Next frame state and result for the held request
    always_comb begin
        n_state    = r_state;
        n_len_lo   = r_len_lo;
        n_len_hi   = r_len_hi;
        n_left     = r_left;
        w_res_vld  = 1'b0;
        w_res_byte = '0;
        w_res_last = 1'b1;
        w_res_kind = KIND_DATA;
        if (r_stg_func == FUNC_DISCONNECT) begin
            // Drop back to hunting; flag an abort once a sync word was seen
            w_res_vld  = (r_state != ST_HUNT1) && (r_state != ST_HUNT2);
            w_res_kind = KIND_ABORT;
            n_state    = ST_HUNT1;
            n_len_lo   = '0;
            n_len_hi   = 1'b0;
            n_left     = '0;
        end else begin
            unique case (r_state)
                ST_HUNT2: begin
                    if (r_stg_byte == w_cfg.sync_second) begin
                        n_state = ST_LEN0;
                    end else if (r_stg_byte != w_cfg.sync_first) begin
                        n_state = ST_HUNT1;
                    end
                end
                ST_LEN0: begin
                    n_len_lo = LEN_W'(r_stg_byte);
                    n_len_hi = 1'b0;
                    n_state  = ST_LEN1;
                end
                ST_LEN1: begin
                    n_len_lo = {r_stg_byte[LEN_W-BYTE_W-1:0], r_len_lo[BYTE_W-1:0]};
                    n_len_hi = r_stg_byte[BYTE_W-1:LEN_W-BYTE_W] != '0;
                    n_state  = ST_LEN2;
                end
                ST_LEN2: begin
                    n_len_hi = w_hi_all;
                    n_state  = ST_LEN3;
                end
                ST_LEN3: begin
                    // Check the gathered length
                    if (!w_hi_all && r_len_lo == '0) begin
                        w_res_vld  = 1'b1;
                        w_res_kind = KIND_EMPTY;
                        n_state    = ST_HUNT1;
                        n_len_lo   = '0;
                        n_len_hi   = 1'b0;
                    end else if (w_hi_all || r_len_lo > w_cfg.limit) begin
                        w_res_vld  = 1'b1;
                        w_res_kind = KIND_OVERSIZE;
                        n_state    = ST_HUNT1;
                        n_len_lo   = '0;
                        n_len_hi   = 1'b0;
                    end else begin
                        n_left  = r_len_lo;
                        n_state = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD: begin
                    // Pass the byte; mark the last one and resume hunting
                    w_res_vld  = 1'b1;
                    w_res_byte = r_stg_byte;
                    w_res_last = (w_left_dec == '0);
                    n_left     = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_state  = ST_HUNT1;
                        n_len_lo = '0;
                        n_len_hi = 1'b0;
                    end
                end
                default: begin
                    n_state = (r_stg_byte == w_cfg.sync_first) ? ST_HUNT2 : ST_HUNT1;
                end
            endcase
        end
    end

    // Hold frame state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT1;
            r_len_lo  <= '0;
            r_len_hi  <= 1'b0;
            r_left    <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_state   <= n_state;
            r_len_lo  <= n_len_lo;
            r_len_hi  <= n_len_hi;
            r_left    <= n_left;
            r_out_vld <= w_res_vld;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_vld) begin
            r_out_byte <= w_res_byte;
            r_out_last <= w_res_last;
            r_out_kind <= w_res_kind;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.last         = r_out_last;
    assign o_out.kind         = r_out_kind;

endmodule

>>> hw/rtl/slpd_cfg.sv
// ----------------------------------------------------------------------------
// slpd_cfg - configuration registers
// Holds the sync word and the payload maximum, and derives the accepted
// length limit as the smaller of the maximum and the buffer cap.
// ----------------------------------------------------------------------------
module slpd_cfg
    import slpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic [LEN_W-1:0]  r_max_payload;

    // Write the addressed register; ignore indexes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Cap the maximum at what the buffer holds
    always_comb begin
        o_cfg.sync_first  = r_sync_first;
        o_cfg.sync_second = r_sync_second;
        if (32'(r_max_payload) < 32'(CAP_LIMIT)) begin
            o_cfg.limit = r_max_payload;
        end else begin
            o_cfg.limit = LEN_W'(CAP_LIMIT);
        end
    end

endmodule
